### sv/mcb_pkg.sv
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared constants and types for the maze carver: map geometry, cell codes,
// direction codes, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package mcb_pkg;

  // Map geometry: one map entry per (x, y), addressed as {x, y}
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COORD_W    = 6;
  localparam int MAP_AW     = 2 * COORD_W;
  localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH_W    = MAP_AW + 1;
  localparam int LIMIT_W    = 7;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [1:0]         cell_t;
  typedef logic [1:0]         dir_t;

  // Cell codes
  localparam cell_t CELL_FREE    = 2'd0;
  localparam cell_t CELL_PATH    = 2'd1;
  localparam cell_t CELL_BLOCKED = 2'd2;

  // Direction codes
  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_RIGHT = 2'd1;
  localparam dir_t DIR_DOWN  = 2'd2;
  localparam dir_t DIR_LEFT  = 2'd3;

  // Operation codes
  localparam logic OP_BLOCK = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Register indexes on the configuration port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [LIMIT_W-1:0] GRID_RESET = 7'd16;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP  = 7'd64;

endpackage

### sv/mcb_ram.sv
// ----------------------------------------------------------------------------
// mcb_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/maze_carver_backtracking_unit.sv
// ----------------------------------------------------------------------------
// maze_carver_backtracking_unit
// Depth-first maze carver. The cell map and the position stack
// live in synchronous RAMs; a small sequencer probes neighbours, backtracks
// and carves.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Transfer
//  --------  ---------------------------------------------  -----------------------
//  command   start, busy, operation, cell_x, cell_y,        start & !busy
//            direction
//  result    result_valid, carved, new_x, new_y,            result_valid (1 cycle)
//            carve_direction, finished
//  config    psel, penable, pwrite, paddr, pwdata,          psel & penable & pwrite
//            prdata, pready
//
// After rst the map is swept clear, one entry a cycle, with busy high; the
// start cell (1,1) is written as path during that sweep. A block item, or a
// step item once the maze is finished, is answered from idle; any other step
// probes neighbours one at a time (up to 4 per cell, one map read port) and
// pops the stack while backtracking.
// The result strobe follows the last cycle of an item; the receiver cannot
// stall it.
// ----------------------------------------------------------------------------
module maze_carver_backtracking_unit (
  input  logic        clk,
  input  logic        rst,
  // command
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [1:0]  direction,
  // result
  output logic        result_valid,
  output logic        carved,
  output logic [5:0]  new_x,
  output logic [5:0]  new_y,
  output logic [1:0]  carve_direction,
  output logic        finished,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;

  localparam logic [mcb_pkg::MAP_AW-1:0] START_ADDR =
    {mcb_pkg::COORD_W'(1), mcb_pkg::COORD_W'(1)};
  localparam logic [mcb_pkg::DEPTH_W-1:0] STACK_FULL =
    mcb_pkg::DEPTH_W'(mcb_pkg::MAP_DEPTH);

  logic [2:0]                      state;
  logic [mcb_pkg::MAP_AW-1:0]      clr_cnt;
  logic [mcb_pkg::LIMIT_W-1:0]     grid_width;
  logic [mcb_pkg::LIMIT_W-1:0]     grid_height;
  mcb_pkg::coord_t                 cur_x;
  mcb_pkg::coord_t                 cur_y;
  logic [mcb_pkg::DEPTH_W-1:0]     stack_depth;
  logic                            done_flag;
  mcb_pkg::dir_t                   req_dir;
  logic [1:0]                      probe_cnt;

  // Memory ports
  logic                            map_we;
  logic [mcb_pkg::MAP_AW-1:0]      map_waddr;
  mcb_pkg::cell_t                  map_wdata;
  logic [mcb_pkg::MAP_AW-1:0]      map_raddr;
  mcb_pkg::cell_t                  map_rdata;
  logic                            stk_we;
  logic [mcb_pkg::MAP_AW-1:0]      stk_raddr;
  logic [mcb_pkg::MAP_AW-1:0]      stk_rdata;

  // Neighbour probe
  logic [mcb_pkg::LIMIT_W-1:0]     x_lim;
  logic [mcb_pkg::LIMIT_W-1:0]     y_lim;
  mcb_pkg::dir_t                   probe_dir;
  mcb_pkg::coord_t                 nb_x;
  mcb_pkg::coord_t                 nb_y;
  logic                            nb_ok;
  logic                            eval_now;
  logic                            nb_free;
  logic                            accept;
  logic                            cfg_wr;
  logic                            do_carve;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Clip the grid limits to the map size
  assign x_lim = (grid_width  > mcb_pkg::LIMIT_CAP) ? mcb_pkg::LIMIT_CAP : grid_width;
  assign y_lim = (grid_height > mcb_pkg::LIMIT_CAP) ? mcb_pkg::LIMIT_CAP : grid_height;

  // Neighbour of the current cell in the probed direction
  assign probe_dir = req_dir + probe_cnt;

  always_comb begin
    nb_x  = cur_x;
    nb_y  = cur_y;
    nb_ok = 1'b0;
    case (probe_dir)
      mcb_pkg::DIR_UP: begin
        nb_ok = (cur_y >= mcb_pkg::COORD_W'(2));
        nb_y  = cur_y - mcb_pkg::COORD_W'(1);
      end
      mcb_pkg::DIR_RIGHT: begin
        nb_ok = ({1'b0, cur_x} + mcb_pkg::LIMIT_W'(1)) < x_lim;
        nb_x  = cur_x + mcb_pkg::COORD_W'(1);
      end
      mcb_pkg::DIR_DOWN: begin
        nb_ok = ({1'b0, cur_y} + mcb_pkg::LIMIT_W'(1)) < y_lim;
        nb_y  = cur_y + mcb_pkg::COORD_W'(1);
      end
      default: begin
        nb_ok = (cur_x >= mcb_pkg::COORD_W'(2));
        nb_x  = cur_x - mcb_pkg::COORD_W'(1);
      end
    endcase
  end

  // A probe resolves when its map read returns, or at once when out of range
  assign eval_now = (state == S_EVAL) || ((state == S_PROBE) && !nb_ok);
  assign nb_free  = (state == S_EVAL) && (map_rdata == mcb_pkg::CELL_FREE);
  assign do_carve = eval_now && nb_free && (probe_cnt == 2'd0) &&
                    (stack_depth < STACK_FULL);

  // Map write port: clearing sweep, block item, carve
  always_comb begin
    map_we    = 1'b0;
    map_waddr = {nb_x, nb_y};
    map_wdata = mcb_pkg::CELL_PATH;
    if (state == S_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = clr_cnt;
      map_wdata = (clr_cnt == START_ADDR) ? mcb_pkg::CELL_PATH : mcb_pkg::CELL_FREE;
    end else if (accept && operation == mcb_pkg::OP_BLOCK) begin
      map_we    = 1'b1;
      map_waddr = {cell_x, cell_y};
      map_wdata = mcb_pkg::CELL_BLOCKED;
    end else if (do_carve) begin
      map_we    = 1'b1;
    end
  end

  assign map_raddr = {nb_x, nb_y};
  assign stk_we    = do_carve;
  assign stk_raddr = stack_depth[mcb_pkg::MAP_AW-1:0] - mcb_pkg::MAP_AW'(1);

  mcb_ram #(
    .WIDTH (2),
    .DEPTH (mcb_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  mcb_ram #(
    .WIDTH (mcb_pkg::MAP_AW),
    .DEPTH (mcb_pkg::MAP_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stack_depth[mcb_pkg::MAP_AW-1:0]),
    .wdata ({cur_x, cur_y}),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= mcb_pkg::GRID_RESET;
      grid_height <= mcb_pkg::GRID_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == mcb_pkg::REG_WIDTH) begin
        grid_width <= pwdata[mcb_pkg::LIMIT_W-1:0];
      end else begin
        grid_height <= pwdata[mcb_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mcb_pkg::REG_HEIGHT) begin
      prdata = {25'd0, grid_height};
    end else begin
      prdata = {25'd0, grid_width};
    end
  end

  // Sequencer: clear, probe neighbours, backtrack, carve, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      cur_x        <= mcb_pkg::COORD_W'(1);
      cur_y        <= mcb_pkg::COORD_W'(1);
      stack_depth  <= '0;
      done_flag    <= 1'b0;
      result_valid <= 1'b0;
      probe_cnt    <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + mcb_pkg::MAP_AW'(1);
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_dir   <= direction;
            probe_cnt <= '0;
            if (operation == mcb_pkg::OP_STEP && !done_flag) begin
              state <= S_PROBE;
            end else begin
              result_valid    <= 1'b1;
              carved          <= 1'b0;
              carve_direction <= mcb_pkg::DIR_UP;
              new_x           <= cur_x;
              new_y           <= cur_y;
              finished        <= done_flag;
            end
          end
        end
        S_PROBE, S_EVAL: begin
          if (!eval_now) begin
            // in range: wait for the map read
            state <= S_EVAL;
          end else if (nb_free) begin
            // a free neighbour exists: carve only toward the requested one
            state           <= S_IDLE;
            result_valid    <= 1'b1;
            finished        <= 1'b0;
            carved          <= do_carve;
            carve_direction <= do_carve ? req_dir : mcb_pkg::DIR_UP;
            new_x           <= do_carve ? nb_x : cur_x;
            new_y           <= do_carve ? nb_y : cur_y;
            if (do_carve) begin
              cur_x       <= nb_x;
              cur_y       <= nb_y;
              stack_depth <= stack_depth + mcb_pkg::DEPTH_W'(1);
            end
          end else if (probe_cnt != 2'd3) begin
            // advance to the next direction
            probe_cnt <= probe_cnt + 2'd1;
            state     <= S_PROBE;
          end else if (stack_depth == '0) begin
            // dead end with nothing to pop: maze complete
            done_flag       <= 1'b1;
            state           <= S_IDLE;
            result_valid    <= 1'b1;
            finished        <= 1'b1;
            carved          <= 1'b0;
            carve_direction <= mcb_pkg::DIR_UP;
            new_x           <= cur_x;
            new_y           <= cur_y;
          end else begin
            // dead end: pop the stack
            stack_depth <= stack_depth - mcb_pkg::DEPTH_W'(1);
            state       <= S_POP;
          end
        end
        S_POP: begin
          cur_x     <= stk_rdata[mcb_pkg::MAP_AW-1:mcb_pkg::COORD_W];
          cur_y     <= stk_rdata[mcb_pkg::COORD_W-1:0];
          probe_cnt <= '0;
          state     <= S_PROBE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/sv/maze_carver_backtracking_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_carver_backtracking_unit_tb
// Self-checking bench for the depth-first maze carver. Block and step commands
// go in over the start/busy handshake. A scoreboard keeps its own copy of the
// cell map, the position stack and the grid registers, predicts every result,
// and checks each result strobe field by field in arrival order. Grid sizes
// are reprogrammed over APB between phases, while the carver is idle.
// ----------------------------------------------------------------------------
module maze_carver_backtracking_unit_tb;

  typedef struct {
    logic            carved;
    mcb_pkg::coord_t x;
    mcb_pkg::coord_t y;
    mcb_pkg::dir_t   dir;
    logic            finished;
  } carve_result_t;

  // Predicts carver results and checks them against the block
  class carve_scoreboard;
    mcb_pkg::cell_t                cell_map [mcb_pkg::MAX_WIDTH][mcb_pkg::MAX_HEIGHT];
    logic [mcb_pkg::MAP_AW-1:0]    trail [mcb_pkg::MAP_DEPTH];
    int                            trail_depth;
    int                            cur_x;
    int                            cur_y;
    bit                            done;
    logic [mcb_pkg::LIMIT_W-1:0]   grid_w;
    logic [mcb_pkg::LIMIT_W-1:0]   grid_h;
    carve_result_t                 pending [$];
    int                            mismatches;

    function new();
      foreach (cell_map[i, j]) cell_map[i][j] = mcb_pkg::CELL_FREE;
      cell_map[1][1] = mcb_pkg::CELL_PATH;
      trail_depth = 0;
      cur_x = 1;
      cur_y = 1;
      done = 0;
      grid_w = mcb_pkg::GRID_RESET;
      grid_h = mcb_pkg::GRID_RESET;
      mismatches = 0;
    endfunction

    function void set_grid(logic idx, logic [31:0] value);
      if (idx == mcb_pkg::REG_WIDTH) grid_w = value[mcb_pkg::LIMIT_W-1:0];
      else grid_h = value[mcb_pkg::LIMIT_W-1:0];
    endfunction

    // Registers above the map size act as the map size
    function int clip_limit(logic [mcb_pkg::LIMIT_W-1:0] r);
      return (r > mcb_pkg::LIMIT_CAP) ? int'(mcb_pkg::LIMIT_CAP) : int'(r);
    endfunction

    // Neighbour of the current cell; 0 when it falls outside the grid
    function bit step_to(mcb_pkg::dir_t d, output int nx, output int ny);
      int xl;
      int yl;
      xl = clip_limit(grid_w);
      yl = clip_limit(grid_h);
      nx = cur_x;
      ny = cur_y;
      case (d)
        mcb_pkg::DIR_UP: begin
          if (cur_y < 2) return 0;
          ny = cur_y - 1;
        end
        mcb_pkg::DIR_RIGHT: begin
          if (cur_x + 1 >= xl) return 0;
          nx = cur_x + 1;
        end
        mcb_pkg::DIR_DOWN: begin
          if (cur_y + 1 >= yl) return 0;
          ny = cur_y + 1;
        end
        default: begin
          if (cur_x < 2) return 0;
          nx = cur_x - 1;
        end
      endcase
      return 1;
    endfunction

    function bit has_opening();
      int nx;
      int ny;
      for (int d = 0; d < 4; d++) begin
        if (step_to(mcb_pkg::dir_t'(d), nx, ny) &&
            cell_map[nx][ny] == mcb_pkg::CELL_FREE) return 1;
      end
      return 0;
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void note_command(logic op, mcb_pkg::coord_t cx, mcb_pkg::coord_t cy,
                               mcb_pkg::dir_t d);
      carve_result_t r;
      int nx;
      int ny;
      r.carved = 0;
      r.dir = mcb_pkg::DIR_UP;  // direction reads as zero when nothing is carved
      if (op == mcb_pkg::OP_BLOCK) begin
        cell_map[cx][cy] = mcb_pkg::CELL_BLOCKED;
      end else if (!done) begin
        // backtrack while boxed in; an empty stack completes the maze
        while (!done && !has_opening()) begin
          if (trail_depth == 0) begin
            done = 1;
          end else begin
            trail_depth--;
            cur_x = trail[trail_depth][mcb_pkg::MAP_AW-1:mcb_pkg::COORD_W];
            cur_y = trail[trail_depth][mcb_pkg::COORD_W-1:0];
          end
        end
        if (!done && step_to(d, nx, ny) && cell_map[nx][ny] == mcb_pkg::CELL_FREE &&
            trail_depth < mcb_pkg::MAP_DEPTH) begin
          cell_map[nx][ny] = mcb_pkg::CELL_PATH;
          trail[trail_depth] = {mcb_pkg::coord_t'(cur_x), mcb_pkg::coord_t'(cur_y)};
          trail_depth++;
          cur_x = nx;
          cur_y = ny;
          r.carved = 1;
          r.dir = d;
        end
      end
      r.x = mcb_pkg::coord_t'(cur_x);
      r.y = mcb_pkg::coord_t'(cur_y);
      r.finished = done;
      pending.push_back(r);
    endfunction

    function void check_result(logic got_carved, mcb_pkg::coord_t got_x,
                               mcb_pkg::coord_t got_y, mcb_pkg::dir_t got_dir,
                               logic got_finished);
      carve_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none expected: carved=%0b x=%0d y=%0d dir=%0d fin=%0b",
                   $realtime, got_carved, got_x, got_y, got_dir, got_finished);
        return;
      end
      e = pending.pop_front();
      if (e.carved !== got_carved || e.x !== got_x || e.y !== got_y ||
          e.dir !== got_dir || e.finished !== got_finished) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch: exp carved=%0b x=%0d y=%0d dir=%0d fin=%0b,",
                   $realtime, e.carved, e.x, e.y, e.dir, e.finished);
          $display("    got carved=%0b x=%0d y=%0d dir=%0d fin=%0b",
                   got_carved, got_x, got_y, got_dir, got_finished);
        end
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic            operation;
  mcb_pkg::coord_t cell_x;
  mcb_pkg::coord_t cell_y;
  mcb_pkg::dir_t   direction;
  logic            result_valid;
  logic            carved;
  mcb_pkg::coord_t new_x;
  mcb_pkg::coord_t new_y;
  mcb_pkg::dir_t   carve_direction;
  logic            finished;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  carve_scoreboard sb;

  maze_carver_backtracking_unit dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .direction       (direction),
    .result_valid    (result_valid),
    .carved          (carved),
    .new_x           (new_x),
    .new_y           (new_y),
    .carve_direction (carve_direction),
    .finished        (finished),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_result(carved, new_x, new_y, carve_direction, finished);
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Hold start high until the command transfer, then note it
  task automatic send_command(logic op, mcb_pkg::coord_t cx, mcb_pkg::coord_t cy,
                              mcb_pkg::dir_t d, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    cell_x <= cx;
    cell_y <= cy;
    direction <= d;
    do @(posedge clk); while (busy);
    sb.note_command(op, cx, cy, d);
  endtask

  task automatic send_step(mcb_pkg::dir_t d);
    send_command(mcb_pkg::OP_STEP, mcb_pkg::coord_t'($urandom), mcb_pkg::coord_t'($urandom),
                 d, pick_gap());
  endtask

  task automatic send_block(int x, int y);
    send_command(mcb_pkg::OP_BLOCK, mcb_pkg::coord_t'(x), mcb_pkg::coord_t'(y),
                 mcb_pkg::dir_t'($urandom), pick_gap());
  endtask

  // Drop start and wait until every result is in and the carver is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy);
  endtask

  // Write both grid registers over APB; upper data bits carry noise
  task automatic program_grid(logic [mcb_pkg::LIMIT_W-1:0] w,
                              logic [mcb_pkg::LIMIT_W-1:0] h);
    logic [31:0] word;
    logic        idx;
    drain();
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? mcb_pkg::REG_WIDTH : mcb_pkg::REG_HEIGHT;
      word = $urandom;
      word[mcb_pkg::LIMIT_W-1:0] = (idx == mcb_pkg::REG_WIDTH) ? w : h;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= word;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_grid(idx, word);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Edge cells, dead-end moves, overwriting path and current cells, one backtrack
  task automatic run_directed();
    send_block(0, 0);
    send_block(63, 63);
    send_block(63, 0);
    send_block(0, 63);
    send_block(3, 1);
    send_step(mcb_pkg::DIR_UP);
    send_step(mcb_pkg::DIR_LEFT);
    send_step(mcb_pkg::DIR_RIGHT);
    send_step(mcb_pkg::DIR_RIGHT);
    send_step(mcb_pkg::DIR_DOWN);
    send_step(mcb_pkg::DIR_LEFT);
    send_step(mcb_pkg::DIR_UP);
    send_block(1, 2);
    send_block(2, 1);
    send_step(mcb_pkg::DIR_DOWN);
    send_step(mcb_pkg::DIR_DOWN);
    send_block(2, 4);
    send_block(1, 5);
    send_step(mcb_pkg::DIR_RIGHT);
    send_step(mcb_pkg::DIR_DOWN);
  endtask

  // Mostly steps; blocks land mostly inside the current grid
  task automatic carve_random(int count, int block_pct);
    logic            op;
    mcb_pkg::coord_t cx;
    mcb_pkg::coord_t cy;
    int              lim_x;
    int              lim_y;
    bit              quiet;
    quiet = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      op = ($urandom_range(0, 99) < block_pct) ? mcb_pkg::OP_BLOCK : mcb_pkg::OP_STEP;
      cx = mcb_pkg::coord_t'($urandom);
      cy = mcb_pkg::coord_t'($urandom);
      if (op == mcb_pkg::OP_BLOCK && $urandom_range(0, 9) < 7) begin
        lim_x = sb.clip_limit(sb.grid_w);
        lim_y = sb.clip_limit(sb.grid_h);
        if (lim_x >= 2) cx = mcb_pkg::coord_t'($urandom_range(1, lim_x - 1));
        if (lim_y >= 2) cy = mcb_pkg::coord_t'($urandom_range(1, lim_y - 1));
      end
      send_command(op, cx, cy, mcb_pkg::dir_t'($urandom), quiet ? 0 : pick_gap());
    end
  endtask

  // Keep carving until the stack runs dry, or until cap commands are sent
  task automatic carve_until_finished(int cap);
    int n;
    n = 0;
    while (!sb.done && n < cap) begin
      carve_random(1, 3);
      n++;
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    operation <= mcb_pkg::OP_BLOCK;
    cell_x <= '0;
    cell_y <= '0;
    direction <= mcb_pkg::DIR_UP;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    program_grid(7'd127, 7'd64);
    carve_random(60, 8);
    program_grid(7'd0, 7'd2);
    carve_random(20, 8);
    program_grid(7'd65, 7'd3);
    carve_random(20, 8);
    program_grid(7'd24, 7'd24);
    carve_random(500, 8);
    program_grid(7'd20, 7'd30);
    carve_random(500, 8);
    carve_until_finished(700);
    // steps after completion only repeat the final cell
    program_grid(7'd3, 7'd127);
    carve_random(12, 30);

    drain();
    repeat (16) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0d results never arrived", sb.pending.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Slowest run: the clear sweep, ~1900 commands and at most 4096 pops; the
  // timeout leaves ample margin
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
